>>> design/sfpt_pkg.sv
`default_nettype none
package sfpt_pkg;

	localparam int FRAC_BITS    = 8;
	localparam int STEP_DIVISOR = 60;

	localparam int POS_W      = 24;
	localparam int COORD_W    = 16;
	localparam int VIEW_W     = 13;
	localparam int GAIN_W     = 17;
	localparam int GAIN_SHIFT = 16;
	localparam int DIFF_W     = POS_W + 1;
	localparam int WIDE_W     = 2 * DIFF_W;
	localparam int REM_W      = DIFF_W + 3;
	localparam int ITER_STEPS = DIFF_W;
	localparam int CNT_W      = $clog2(ITER_STEPS);
	localparam int CTR_W      = COORD_W + 1;
	localparam int SAT_W      = (CTR_W + FRAC_BITS > DIFF_W + 1) ? CTR_W + FRAC_BITS : DIFF_W + 1;

	localparam logic [WIDE_W-1:0] SNAP_LIMIT = WIDE_W'(1) << (2 * FRAC_BITS);
	localparam logic [DIFF_W-1:0] STEP_MIN   = DIFF_W'(1) << FRAC_BITS;
	localparam logic [DIFF_W-1:0] STEP_DIV   = DIFF_W'(STEP_DIVISOR);
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_SHIFT;

	localparam logic [2:0] OP_JUMP        = 3'd0;
	localparam logic [2:0] OP_JUMP_CTR    = 3'd1;
	localparam logic [2:0] OP_SET_TGT     = 3'd2;
	localparam logic [2:0] OP_SET_TGT_CTR = 3'd3;
	localparam logic [2:0] OP_TICK        = 3'd4;

	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FOLLOW_GAIN = 2'd2;

	localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = VIEW_W'(320);
	localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = VIEW_W'(240);
	localparam logic [GAIN_W-1:0] GAIN_RST        = GAIN_ONE;

	typedef struct packed {
		logic [VIEW_W-1:0] view_width;
		logic [VIEW_W-1:0] view_height;
		logic [GAIN_W-1:0] follow_gain;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             at_target;
	} result_t;

	typedef struct packed {
		logic              start;
		logic              sqrt_mode;
		logic [WIDE_W-1:0] operand;
		logic [DIFF_W-1:0] divisor;
	} iter_req_t;

	typedef struct packed {
		logic              done;
		logic [DIFF_W-1:0] result;
	} iter_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SUM,
		ST_SQRT,
		ST_MUL_G,
		ST_GO_V,
		ST_DIV_V,
		ST_MUL_MX,
		ST_GO_X,
		ST_DIV_X,
		ST_MUL_MY,
		ST_GO_Y,
		ST_DIV_Y,
		ST_UPDATE,
		ST_FIN
	} core_state_t;

	// clamp to the signed position range
	function automatic logic [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
		logic fits;
		fits = (&v[SAT_W-1:POS_W-1]) | ~(|v[SAT_W-1:POS_W-1]);
		if (fits)
			return v[POS_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	function automatic logic [POS_W-1:0] to_fixed(input logic signed [CTR_W-1:0] pix);
		logic signed [SAT_W-1:0] scaled;
		scaled = SAT_W'(pix);
		scaled = scaled <<< FRAC_BITS;
		return sat_pos(scaled);
	endfunction

endpackage
`default_nettype wire

>>> design/smooth_follow_position_tracker.sv
// Channel   Dir  Beat contents
// s_*       in   tuser: opcode[2:0]; tdata: coord_x[15:0], coord_y[31:16]
// m_*       out  tdata: pos_x[23:0], pos_y[47:24]; tuser: at_target[0]
// APB       in   0x0 view_width, 0x4 view_height, 0x8 follow_gain
//
// A tick runs on one shared compare-subtract unit, which takes 25 steps
// each for the square root and three divisions, with a registered
// multiplier between them.
// Jump, target and unknown opcodes go straight to the result state, and a tick that snaps skips the unit.
// s_tready is high only while the sequencer is idle; a result beat waits
// in the output register, and the next input is taken meanwhile.
// Reset clears position, target and registers to their defaults at once.
`default_nettype none
module smooth_follow_position_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // coord_x[15:0], coord_y[31:16]
	input  wire logic [2:0]  s_tuser,   // opcode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // pos_x[23:0], pos_y[47:24]
	output logic [0:0]       m_tuser,   // at_target[0]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfpt_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	logic    idle, fin, out_free, wr_en;
	logic    m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tuser_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view_width  <= VIEW_WIDTH_RST;
			cfg_q.view_height <= VIEW_HEIGHT_RST;
			cfg_q.follow_gain <= GAIN_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_VIEW_WIDTH:  cfg_q.view_width  <= pwdata[VIEW_W-1:0];
				REG_VIEW_HEIGHT: cfg_q.view_height <= pwdata[VIEW_W-1:0];
				REG_FOLLOW_GAIN: cfg_q.follow_gain <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_VIEW_WIDTH:  prdata = 32'(cfg_q.view_width);
			REG_VIEW_HEIGHT: prdata = 32'(cfg_q.view_height);
			REG_FOLLOW_GAIN: prdata = 32'(cfg_q.follow_gain);
			default:         prdata = '0;
		endcase
	end

	assign s_tready = idle;
	assign out_free = !m_tvalid_q || m_tready;

	sfpt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && s_tready),
		.op       (s_tuser),
		.coord_x  (s_tdata[15:0]),
		.coord_y  (s_tdata[31:16]),
		.cfg      (cfg_q),
		.out_free (out_free),
		.idle     (idle),
		.fin      (fin),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (fin)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			m_tdata_q <= {res.pos_y, res.pos_x};
			m_tuser_q <= res.at_target;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

>>> design/sfpt_iter.sv
`default_nettype none
module sfpt_iter (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sfpt_pkg::iter_req_t  req,
	output sfpt_pkg::iter_rsp_t       rsp
);
	import sfpt_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              sqrt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] opnd_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIFF_W-1:0] res_q;
	logic [DIFF_W-1:0] div_q;
	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  trial;
	logic [REM_W:0]    diff;
	logic              fits;

	// one compare-subtract per cycle: a root digit or a quotient bit
	always_comb begin
		if (sqrt_q) begin
			shifted = {rem_q[REM_W-3:0], opnd_q[WIDE_W-1 -: 2]};
			trial   = {{(REM_W-DIFF_W-2){1'b0}}, res_q, 2'b01};
		end else begin
			shifted = {rem_q[REM_W-2:0], opnd_q[WIDE_W-1]};
			trial   = {{(REM_W-DIFF_W){1'b0}}, div_q};
		end
		diff = {1'b0, shifted} - {1'b0, trial};
		fits = ~diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ITER_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt_mode;
			div_q  <= req.divisor;
			res_q  <= '0;
			if (req.sqrt_mode) begin
				opnd_q <= req.operand;
				rem_q  <= '0;
			end else begin
				// upper half seeds the remainder, lower half shifts in
				opnd_q <= {req.operand[WIDE_W-DIFF_W-1:0], {DIFF_W{1'b0}}};
				rem_q  <= {{(REM_W-WIDE_W+DIFF_W){1'b0}}, req.operand[WIDE_W-1:DIFF_W]};
			end
		end else if (busy_q) begin
			rem_q  <= fits ? diff[REM_W-1:0] : shifted;
			res_q  <= {res_q[DIFF_W-2:0], fits};
			opnd_q <= sqrt_q ? (opnd_q << 2) : (opnd_q << 1);
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule
`default_nettype wire

>>> design/sfpt_core.sv
`default_nettype none
module sfpt_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [2:0]                    op,
	input  wire logic [sfpt_pkg::COORD_W-1:0]  coord_x,
	input  wire logic [sfpt_pkg::COORD_W-1:0]  coord_y,
	input  wire sfpt_pkg::cfg_t                cfg,
	input  wire logic                          out_free,
	output logic                               idle,
	output logic                               fin,
	output sfpt_pkg::result_t                  res
);
	import sfpt_pkg::*;

	core_state_t state_q, state_d;

	logic [POS_W-1:0]  pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
	logic [DIFF_W-1:0] ax_q, ay_q, d_q, v_q, mvx_q, mvy_q;
	logic              sx_q, sy_q;
	logic [WIDE_W-1:0] prod_q, acc_q;

	iter_req_t         req;
	iter_rsp_t         rsp;

	logic [DIFF_W-1:0] mul_a, mul_b;
	logic [WIDE_W-1:0] prod_c;
	logic [WIDE_W-1:0] dist_sq;
	logic              snap;
	logic [GAIN_W-1:0] gain_eff;
	logic [DIFF_W-1:0] dx_c, dy_c;
	logic              centred;
	logic signed [CTR_W-1:0] cx, cy;
	logic [POS_W-1:0]  fix_x, fix_y;
	logic signed [DIFF_W:0] new_x, new_y;
	logic [DIFF_W:0]   move_x, move_y;

	sfpt_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		dx_c = {tgt_x_q[POS_W-1], tgt_x_q} - {pos_x_q[POS_W-1], pos_x_q};
		dy_c = {tgt_y_q[POS_W-1], tgt_y_q} - {pos_y_q[POS_W-1], pos_y_q};

		centred = (op == OP_JUMP_CTR) || (op == OP_SET_TGT_CTR);
		cx = {coord_x[COORD_W-1], coord_x}
			- (centred ? CTR_W'(cfg.view_width[VIEW_W-1:1]) : CTR_W'(0));
		cy = {coord_y[COORD_W-1], coord_y}
			- (centred ? CTR_W'(cfg.view_height[VIEW_W-1:1]) : CTR_W'(0));
		fix_x = to_fixed(cx);
		fix_y = to_fixed(cy);

		gain_eff = (cfg.follow_gain > GAIN_ONE) ? GAIN_ONE : cfg.follow_gain;
		dist_sq  = acc_q + prod_q;
		snap     = (dist_sq <= SNAP_LIMIT);

		move_x = sx_q ? -{1'b0, mvx_q} : {1'b0, mvx_q};
		move_y = sy_q ? -{1'b0, mvy_q} : {1'b0, mvy_q};
		new_x  = {{2{pos_x_q[POS_W-1]}}, pos_x_q} + move_x;
		new_y  = {{2{pos_y_q[POS_W-1]}}, pos_y_q} + move_y;

		prod_c = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		req     = '0;
		mul_a   = ax_q;
		mul_b   = ax_q;
		fin     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = (op == OP_TICK) ? ST_MUL_X : ST_FIN;
			end
			ST_MUL_X: state_d = ST_MUL_Y;
			ST_MUL_Y: begin
				mul_a   = ay_q;
				mul_b   = ay_q;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (snap) begin
					state_d = ST_FIN;
				end else begin
					req.start     = 1'b1;
					req.sqrt_mode = 1'b1;
					req.operand   = dist_sq;
					state_d       = ST_SQRT;
				end
			end
			ST_SQRT: if (rsp.done) state_d = ST_MUL_G;
			ST_MUL_G: begin
				mul_a   = d_q;
				mul_b   = DIFF_W'(gain_eff);
				state_d = ST_GO_V;
			end
			ST_GO_V: begin
				req.start   = 1'b1;
				req.operand = prod_q >> GAIN_SHIFT;
				req.divisor = STEP_DIV;
				state_d     = ST_DIV_V;
			end
			ST_DIV_V: if (rsp.done) state_d = ST_MUL_MX;
			ST_MUL_MX: begin
				mul_b   = v_q;
				state_d = ST_GO_X;
			end
			ST_GO_X: begin
				req.start   = 1'b1;
				req.operand = prod_q;
				req.divisor = d_q;
				state_d     = ST_DIV_X;
			end
			ST_DIV_X: if (rsp.done) state_d = ST_MUL_MY;
			ST_MUL_MY: begin
				mul_a   = ay_q;
				mul_b   = v_q;
				state_d = ST_GO_Y;
			end
			ST_GO_Y: begin
				req.start   = 1'b1;
				req.operand = prod_q;
				req.divisor = d_q;
				state_d     = ST_DIV_Y;
			end
			ST_DIV_Y: if (rsp.done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_FIN;
			ST_FIN: begin
				// hold until the output register can take the beat
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
		end else begin
			if (state_q == ST_IDLE && start && op <= OP_SET_TGT_CTR) begin
				tgt_x_q <= fix_x;
				tgt_y_q <= fix_y;
				if (op <= OP_JUMP_CTR) begin
					pos_x_q <= fix_x;
					pos_y_q <= fix_y;
				end
			end
			if (state_q == ST_SUM && snap) begin
				pos_x_q <= tgt_x_q;
				pos_y_q <= tgt_y_q;
			end
			if (state_q == ST_UPDATE) begin
				pos_x_q <= sat_pos(SAT_W'(new_x));
				pos_y_q <= sat_pos(SAT_W'(new_y));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (state_q == ST_IDLE) begin
			sx_q <= dx_c[DIFF_W-1];
			sy_q <= dy_c[DIFF_W-1];
			ax_q <= dx_c[DIFF_W-1] ? -dx_c : dx_c;
			ay_q <= dy_c[DIFF_W-1] ? -dy_c : dy_c;
		end
		if (state_q == ST_MUL_Y)
			acc_q <= prod_q;
		if (state_q == ST_SQRT && rsp.done)
			d_q <= (rsp.result == '0) ? DIFF_W'(1) : rsp.result;
		if (state_q == ST_DIV_V && rsp.done)
			v_q <= (rsp.result < STEP_MIN) ? STEP_MIN : rsp.result;
		if (state_q == ST_DIV_X && rsp.done)
			mvx_q <= rsp.result;
		if (state_q == ST_DIV_Y && rsp.done)
			mvy_q <= rsp.result;
	end

	assign idle          = (state_q == ST_IDLE);
	assign res.pos_x     = pos_x_q;
	assign res.pos_y     = pos_y_q;
	assign res.at_target = (pos_x_q == tgt_x_q) && (pos_y_q == tgt_y_q);

endmodule
`default_nettype wire

>>> design/sfpt_check.sv
`default_nettype none
module sfpt_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [0:0]  m_tuser,
	input wire logic        pready
);
	import sfpt_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// the sequencer leaves idle right after it takes a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again without any work cycle");

	// a jump lands on the target
	a_jump_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && (s_tuser == OP_JUMP || s_tuser == OP_JUMP_CTR)
		|=> ##1 m_tvalid && m_tuser[0])
		else $error("jump result not at target");

	a_jump_position: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && s_tuser == OP_JUMP
		|=> ##1 m_tdata[23:0] == {$past(s_tdata[15:0], 2), {FRAC_BITS{1'b0}}})
		else $error("jump result position wrong");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind smooth_follow_position_tracker sfpt_check u_sfpt_check (.*);
`default_nettype wire
